### rtl/sorted_index_key_lookup_unit_macros.svh
// assertion macros shared by the lookup unit rtl
// no dependencies; taken in by `include inside module bodies
`ifndef SORTED_INDEX_KEY_LOOKUP_UNIT_MACROS_SVH
`define SORTED_INDEX_KEY_LOOKUP_UNIT_MACROS_SVH

// condition must hold at every edge out of reset
`define SIKL_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define SIKL_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define SIKL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/sikl_pkg.sv
// types, sizes and key helpers for the sorted key lookup unit
// no dependencies; imported by every lookup unit module but sikl_ram
package sikl_pkg;

    localparam int DEPTH    = 1024;
    localparam int MAX_HITS = 64;
    localparam int KEY_BITS = 32;
    localparam int ID_BITS  = 32;
    localparam int IN_W     = 32;

    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int CMP_W   = CNT_W + 1;
    localparam int HIT_W   = $clog2(MAX_HITS + 1);
    localparam int ENTRY_W = KEY_BITS + ID_BITS;

    typedef logic [KEY_BITS-1:0] t_key;

    localparam t_key LOW16_MASK = t_key'(64'h0000_0000_0000_FFFF);

    typedef enum logic [1:0] {
        FUNC_CLEAR = 2'd0,
        FUNC_LOAD  = 2'd1,
        FUNC_EXACT = 2'd2,
        FUNC_RANGE = 2'd3
    } t_func;

    typedef struct packed {
        logic [ID_BITS-1:0] hit_id;
        logic               hit_valid;
        logic               last;
        logic               truncated;
    } t_result;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [ENTRY_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_ram_req;

    // input words are 32 bits, stored keys are KEY_BITS wide
    function automatic t_key fit_key(logic [IN_W-1:0] k);
        return t_key'(k);
    endfunction

    function automatic t_key view_key(t_key k, logic narrow);
        return narrow ? (k & LOW16_MASK) : k;
    endfunction

endpackage

### rtl/sikl_ram.sv
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module sikl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // read data holds while no read is issued
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/sikl_out.sv
// output register of the lookup unit, parts the search from the result stream
// depends on sikl_pkg
module sikl_out (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  sikl_pkg::t_result i_result,
    output logic              o_can_push,
    output logic              o_valid,
    input  logic              i_ready,
    output sikl_pkg::t_result o_result
);
    import sikl_pkg::*;

    logic    r_valid;
    t_result r_result;

    assign o_can_push = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_push && o_can_push) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push && o_can_push) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

### rtl/sikl_search.sv
// table control and search sequencer: clears, loads, binary search probes and walks
// depends on sikl_pkg and sorted_index_key_lookup_unit_macros.svh
module sikl_search (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  sikl_pkg::t_func            i_func,
    input  logic [sikl_pkg::IN_W-1:0]  i_key,
    input  logic [sikl_pkg::ID_BITS-1:0] i_id,
    input  logic [sikl_pkg::IN_W-1:0]  i_limit,
    input  logic                       i_narrow,
    output sikl_pkg::t_ram_req         o_ram,
    input  logic [sikl_pkg::ENTRY_W-1:0] i_rd_data,
    output logic                       o_push,
    output sikl_pkg::t_result          o_result,
    input  logic                       i_can_push
);
    import sikl_pkg::*;
    `include "sorted_index_key_lookup_unit_macros.svh"

    typedef enum logic [2:0] {
        S_IDLE,
        S_PROBE_RD,
        S_PROBE_CMP,
        S_WALK_RD,
        S_WALK_CMP,
        S_FINISH
    } t_state;

    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_count, n_count;
    logic                r_range, n_range;
    t_key                r_lo, n_lo;
    t_key                r_hi, n_hi;
    logic [CNT_W-1:0]    r_left, n_left;
    logic [CNT_W-1:0]    r_rp1, n_rp1;      // right bound plus one
    logic [ADDR_W-1:0]   r_mid, n_mid;
    logic [ADDR_W-1:0]   r_idx, n_idx;
    logic                r_dir_right, n_dir_right;
    logic                r_have_pend, n_have_pend;
    logic [ID_BITS-1:0]  r_pend_id, n_pend_id;
    logic [HIT_W-1:0]    r_emitted, n_emitted;
    logic                r_ovf, n_ovf;

    t_key                rd_key;
    logic [ID_BITS-1:0]  rd_id;
    logic                accept;
    logic [CNT_W-1:0]    mid_calc;
    logic                probe_hit;
    logic                walk_hit;
    logic                right_ok;
    logic                idx_next_ok;
    logic                at_cap;
    t_key                in_lo, in_hi;

    assign rd_key = view_key(i_rd_data[ENTRY_W-1:ID_BITS], i_narrow);
    assign rd_id  = i_rd_data[ID_BITS-1:0];
    assign in_lo  = view_key(fit_key(i_key), i_narrow);
    assign in_hi  = view_key(fit_key(i_limit), i_narrow);

    assign o_ready = (r_state == S_IDLE);
    assign accept  = i_valid && o_ready;

    assign mid_calc  = r_left + ((r_rp1 - r_left - CNT_W'(1)) >> 1);
    assign probe_hit = r_range ? (rd_key >= r_lo && rd_key < r_hi) : (rd_key == r_lo);
    assign walk_hit  = r_dir_right ? (r_range ? (rd_key < r_hi) : (rd_key == r_lo))
                                   : (r_range ? (rd_key >= r_lo) : (rd_key == r_lo));
    assign right_ok    = (CMP_W'(r_mid) + CMP_W'(1)) < CMP_W'(r_count);
    assign idx_next_ok = (CMP_W'(r_idx) + CMP_W'(1)) < CMP_W'(r_count);
    assign at_cap      = (r_emitted == HIT_W'(MAX_HITS));

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_range     = r_range;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_left      = r_left;
        n_rp1       = r_rp1;
        n_mid       = r_mid;
        n_idx       = r_idx;
        n_dir_right = r_dir_right;
        n_have_pend = r_have_pend;
        n_pend_id   = r_pend_id;
        n_emitted   = r_emitted;
        n_ovf       = r_ovf;

        o_ram.we    = 1'b0;
        o_ram.waddr = r_count[ADDR_W-1:0];
        o_ram.wdata = {fit_key(i_key), i_id};
        o_ram.re    = 1'b0;
        o_ram.raddr = r_idx;

        o_push             = 1'b0;
        o_result.hit_id    = r_pend_id;
        o_result.hit_valid = 1'b1;
        o_result.last      = 1'b0;
        o_result.truncated = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_func)
                        FUNC_CLEAR: begin
                            n_count = '0;
                        end
                        FUNC_LOAD: begin
                            if (r_count < CNT_W'(DEPTH)) begin
                                o_ram.we = 1'b1;
                                n_count  = r_count + CNT_W'(1);
                            end
                        end
                        FUNC_EXACT, FUNC_RANGE: begin
                            n_range     = (i_func == FUNC_RANGE);
                            n_lo        = in_lo;
                            n_hi        = in_hi;
                            n_left      = '0;
                            n_rp1       = r_count;
                            n_have_pend = 1'b0;
                            n_emitted   = '0;
                            n_ovf       = 1'b0;
                            if ((i_func == FUNC_RANGE && in_lo > in_hi) || r_count == '0) begin
                                n_state = S_FINISH;
                            end else begin
                                n_state = S_PROBE_RD;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_PROBE_RD: begin
                o_ram.re    = 1'b1;
                o_ram.raddr = mid_calc[ADDR_W-1:0];
                n_mid       = mid_calc[ADDR_W-1:0];
                n_state     = S_PROBE_CMP;
            end
            S_PROBE_CMP: begin
                if (probe_hit) begin
                    n_have_pend = 1'b1;
                    n_pend_id   = rd_id;
                    n_emitted   = HIT_W'(1);
                    if (r_mid != '0) begin
                        n_idx       = r_mid - ADDR_W'(1);
                        n_dir_right = 1'b0;
                        n_state     = S_WALK_RD;
                    end else if (right_ok) begin
                        n_idx       = r_mid + ADDR_W'(1);
                        n_dir_right = 1'b1;
                        n_state     = S_WALK_RD;
                    end else begin
                        n_state = S_FINISH;
                    end
                end else begin
                    if (rd_key < r_lo) begin
                        n_left = CNT_W'(r_mid) + CNT_W'(1);
                    end else begin
                        n_rp1 = CNT_W'(r_mid);
                    end
                    n_state = (n_left < n_rp1) ? S_PROBE_RD : S_FINISH;
                end
            end
            S_WALK_RD: begin
                o_ram.re = 1'b1;
                n_state  = S_WALK_CMP;
            end
            S_WALK_CMP: begin
                if (walk_hit && at_cap) begin
                    n_ovf   = 1'b1;
                    n_state = S_FINISH;
                end else if (walk_hit) begin
                    // previous hit leaves now that another one follows it
                    if (i_can_push) begin
                        o_push    = 1'b1;
                        n_pend_id = rd_id;
                        n_emitted = r_emitted + HIT_W'(1);
                        if (r_dir_right) begin
                            if (idx_next_ok) begin
                                n_idx   = r_idx + ADDR_W'(1);
                                n_state = S_WALK_RD;
                            end else begin
                                n_state = S_FINISH;
                            end
                        end else if (r_idx != '0) begin
                            n_idx   = r_idx - ADDR_W'(1);
                            n_state = S_WALK_RD;
                        end else if (right_ok) begin
                            n_idx       = r_mid + ADDR_W'(1);
                            n_dir_right = 1'b1;
                            n_state     = S_WALK_RD;
                        end else begin
                            n_state = S_FINISH;
                        end
                    end
                end else if (!r_dir_right && right_ok) begin
                    n_idx       = r_mid + ADDR_W'(1);
                    n_dir_right = 1'b1;
                    n_state     = S_WALK_RD;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                o_result.hit_id    = r_have_pend ? r_pend_id : '0;
                o_result.hit_valid = r_have_pend;
                o_result.last      = 1'b1;
                o_result.truncated = r_have_pend && r_ovf;
                o_push             = 1'b1;
                if (i_can_push) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_range     <= 1'b0;
            r_lo        <= '0;
            r_hi        <= '0;
            r_left      <= '0;
            r_rp1       <= '0;
            r_mid       <= '0;
            r_idx       <= '0;
            r_dir_right <= 1'b0;
            r_have_pend <= 1'b0;
            r_pend_id   <= '0;
            r_emitted   <= '0;
            r_ovf       <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_range     <= n_range;
            r_lo        <= n_lo;
            r_hi        <= n_hi;
            r_left      <= n_left;
            r_rp1       <= n_rp1;
            r_mid       <= n_mid;
            r_idx       <= n_idx;
            r_dir_right <= n_dir_right;
            r_have_pend <= n_have_pend;
            r_pend_id   <= n_pend_id;
            r_emitted   <= n_emitted;
            r_ovf       <= n_ovf;
        end
    end

    `SIKL_ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= CNT_W'(DEPTH), "entry count past depth")
    `SIKL_ASSERT_ALWAYS(a_emit_bound, i_clk, i_rst_n, r_emitted <= HIT_W'(MAX_HITS), "hit count past limit")
    `SIKL_ASSERT_IMPL(a_walk_pend, i_clk, i_rst_n, r_state == S_WALK_RD || r_state == S_WALK_CMP, r_have_pend, "walk without a held hit")
    `SIKL_ASSERT_IMPL(a_probe_window, i_clk, i_rst_n, r_state == S_PROBE_RD, r_left < r_rp1 && r_rp1 <= r_count, "probe window empty or past count")
    `SIKL_ASSERT_NEXT(a_write_idle, i_clk, i_rst_n, o_ram.we, r_state == S_IDLE, "load left the idle state")

endmodule

### rtl/sorted_index_key_lookup_unit.sv
// top level of the sorted key lookup unit: ports, mode register, table ram
// depends on sikl_pkg, sikl_ram, sikl_search, sikl_out
//
//  channel   direction  accepted when             carries
//  s_axis    in         tvalid & tready           func, key, id, range limit
//  m_axis    out        tvalid & tready           hit id, flags, end of query
//  cfg       in         i_cfg_valid & o_cfg_ready narrow key mode
//
// clear and load leave the unit idle; a load into a full table is dropped
// a query is accepted, then runs binary search probes (at most ceil(log2(n+1))),
// walked entries (hits - 1 plus at most two misses) and a closing state; each probe
// and each walked entry is a read state then a compare state on the one read port
// reset is synchronous and empties the table; no clearing pass is needed
// a stalled result stream holds the search only when a new result must leave
module sorted_index_key_lookup_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [95:0]  s_axis_tdata,   // key_value, entry_id, range_limit
    input  logic [1:0]   s_axis_tuser,   // func
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [31:0]  m_axis_tdata,   // hit_id
    output logic [1:0]   m_axis_tuser,   // hit_valid, truncated
    output logic         m_axis_tlast,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic         i_cfg_data
);
    import sikl_pkg::*;

    logic               r_narrow;
    t_ram_req           ram_req;
    logic [ENTRY_W-1:0] rd_data;
    logic               push;
    logic               can_push;
    t_result            push_res;
    t_result            out_res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_narrow <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_narrow <= i_cfg_data;
        end
    end

    sikl_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_waddr (ram_req.waddr),
        .i_wdata (ram_req.wdata),
        .i_re    (ram_req.re),
        .i_raddr (ram_req.raddr),
        .o_rdata (rd_data)
    );

    sikl_search u_search (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_func     (t_func'(s_axis_tuser)),
        .i_key      (s_axis_tdata[31:0]),
        .i_id       (s_axis_tdata[63:32]),
        .i_limit    (s_axis_tdata[95:64]),
        .i_narrow   (r_narrow),
        .o_ram      (ram_req),
        .i_rd_data  (rd_data),
        .o_push     (push),
        .o_result   (push_res),
        .i_can_push (can_push)
    );

    sikl_out u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_result   (push_res),
        .o_can_push (can_push),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_result   (out_res)
    );

    assign m_axis_tdata = out_res.hit_id;
    assign m_axis_tuser = {out_res.truncated, out_res.hit_valid};
    assign m_axis_tlast = out_res.last;

endmodule

### dv/tb.sv
// self-checking testbench for sorted_index_key_lookup_unit
// depends on sikl_pkg and the lookup unit rtl; predicts every hit stream in a scoreboard class
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sikl_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 16;
    localparam int RUN_LEN = 33;

    // table model plus the queue of hit results still owed by the block
    class lookup_scoreboard;
        t_key             keys [DEPTH];
        logic [ID_BITS-1:0] ids [DEPTH];
        int unsigned      count;
        bit               narrow;
        t_result          expected_hits[$];
        t_result          hits[$];
        bit               overflow;
        int               errors;

        function t_key narrow_view(t_key k);
            return narrow ? t_key'(k[15:0]) : k;
        endfunction

        function bit take_hit(int idx);
            t_result r;
            if (hits.size() >= MAX_HITS) begin
                overflow = 1'b1;
                return 1'b0;
            end
            r = '0;
            r.hit_id = ids[idx];
            r.hit_valid = 1'b1;
            hits.insert(hits.size(), r);
            return 1'b1;
        endfunction

        // binary search, then walk left and right from the first matching probe
        function void probe_table(bit ranged, t_key lo, t_key hi);
            int left, right, mid, i;
            t_key k;
            left = 0;
            right = int'(count) - 1;
            while (left <= right) begin
                mid = left + (right - left) / 2;
                k = narrow_view(keys[mid]);
                if (ranged ? (k >= lo && k < hi) : (k == lo)) begin
                    if (!take_hit(mid)) return;
                    for (i = mid - 1; i >= 0; i--) begin
                        k = narrow_view(keys[i]);
                        if (ranged ? (k < lo) : (k != lo)) break;
                        if (!take_hit(i)) return;
                    end
                    for (i = mid + 1; i < int'(count); i++) begin
                        k = narrow_view(keys[i]);
                        if (ranged ? (k >= hi) : (k != lo)) break;
                        if (!take_hit(i)) return;
                    end
                    return;
                end else if (k < lo) begin
                    left = mid + 1;
                end else begin
                    right = mid - 1;
                end
            end
        endfunction

        function void note_request(t_func op, logic [31:0] key, logic [31:0] id,
                                   logic [31:0] lim);
            t_key lo, hi;
            t_result r;
            case (op)
                FUNC_CLEAR: count = 0;
                FUNC_LOAD: begin
                    if (count < DEPTH) begin
                        keys[count] = t_key'(key);
                        ids[count] = id;
                        count++;
                    end
                end
                default: begin
                    hits.delete();
                    overflow = 1'b0;
                    lo = narrow_view(t_key'(key));
                    hi = narrow_view(t_key'(lim));
                    if (op == FUNC_EXACT || lo <= hi) probe_table(op == FUNC_RANGE, lo, hi);
                    if (hits.size() == 0) begin
                        r = '0;
                        r.last = 1'b1;
                        hits.insert(hits.size(), r);
                    end else begin
                        hits[hits.size()-1].last = 1'b1;
                        hits[hits.size()-1].truncated = overflow;
                    end
                    foreach (hits[j]) expected_hits.insert(expected_hits.size(), hits[j]);
                end
            endcase
        endfunction

        function void check_hit(t_result got);
            t_result want;
            if (expected_hits.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: id %h valid %b last %b trunc %b",
                             got.hit_id, got.hit_valid, got.last, got.truncated);
                return;
            end
            want = expected_hits.pop_front();
            if (got.hit_id !== want.hit_id || got.hit_valid !== want.hit_valid ||
                got.last !== want.last || got.truncated !== want.truncated) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: want id/v/l/t %h/%b/%b/%b, got %h/%b/%b/%b",
                             want.hit_id, want.hit_valid, want.last, want.truncated,
                             got.hit_id, got.hit_valid, got.last, got.truncated);
            end
        endfunction
    endclass

    logic         i_clk = 1'b0;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [95:0]  s_axis_tdata;
    logic [1:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [31:0]  m_axis_tdata;
    logic [1:0]   m_axis_tuser;
    logic         m_axis_tlast;
    logic         i_cfg_valid;
    logic         o_cfg_ready;
    logic         i_cfg_data;

    lookup_scoreboard sb = new();
    int           src_idle_pct;
    int           sink_stall_pct;
    int           items_sent;
    int           cycles;
    bit           mode_narrow;
    logic [31:0]  loaded_keys[$];

    sorted_index_key_lookup_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // result side: check each accepted transaction, then pick next ready
    always @(posedge i_clk) begin : sink
        t_result got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.hit_id = m_axis_tdata;
            got.hit_valid = m_axis_tuser[0];
            got.truncated = m_axis_tuser[1];
            got.last = m_axis_tlast;
            sb.check_hit(got);
        end
        m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    // leaves valid high after acceptance so back-to-back items need no lowering
    task automatic send_item(input t_func op, input logic [31:0] key, input logic [31:0] id,
                             input logic [31:0] lim);
        if ($urandom_range(0, 99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < src_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {lim, id, key};
        s_axis_tuser <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_request(op, key, id, lim);
        items_sent++;
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (sb.expected_hits.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_mode(input bit narrow);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= narrow;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        sb.narrow = narrow;
        mode_narrow = narrow;
    endtask

    task automatic set_idling(input int mode);
        case (mode)
            0: begin src_idle_pct = 0; sink_stall_pct = 0; end
            1: begin src_idle_pct = 49; sink_stall_pct = 0; end
            2: begin src_idle_pct = 0; sink_stall_pct = 49; end
            default: begin src_idle_pct = 29; sink_stall_pct = 29; end
        endcase
    endtask

    task automatic ask_query();
        logic [31:0] a, b, tmp, lim;
        int kind;
        tmp = $urandom;
        a = $urandom;
        b = $urandom;
        kind = $urandom_range(0, 4);
        if (loaded_keys.size() > 0) begin
            a = loaded_keys[$urandom_range(0, loaded_keys.size() - 1)];
            b = loaded_keys[$urandom_range(0, loaded_keys.size() - 1)];
        end
        if (mode_narrow ? (a[15:0] > b[15:0]) : (a > b)) begin
            tmp = a;
            a = b;
            b = tmp;
            tmp = $urandom;
        end
        case (kind)
            0: send_item(FUNC_EXACT, mode_narrow ? {tmp[31:16], a[15:0]} : a, $urandom, $urandom);
            1: send_item(FUNC_EXACT, $urandom, $urandom, $urandom);
            2: begin
                lim = b + $urandom_range(0, 2);
                send_item(FUNC_RANGE, a, $urandom, lim);
            end
            3: send_item(FUNC_RANGE, b + 1, $urandom, a);
            default: send_item(FUNC_RANGE, $urandom, $urandom, $urandom);
        endcase
    endtask

    // clear, a run of loads (mostly ascending, with duplicates), then queries
    task automatic run_sequence();
        int unsigned n, nq;
        bit scrambled;
        logic [31:0] cur, tmp, key;
        n = $urandom_range(1, 3);
        nq = $urandom_range(2, 3);
        scrambled = ($urandom_range(0, 9) == 0);
        cur = mode_narrow ? $urandom_range(0, 16'hFF00) : $urandom_range(0, 32'hFFFF_FF00);
        loaded_keys.delete();
        send_item(FUNC_CLEAR, $urandom, $urandom, $urandom);
        repeat (n) begin
            tmp = $urandom;
            if (scrambled) key = tmp[0] ? $urandom : $urandom_range(0, 8);
            else if (mode_narrow) key = {tmp[31:16], cur[15:0]};
            else key = cur;
            cur += $urandom_range(0, 2);
            loaded_keys.insert(loaded_keys.size(), key);
            send_item(FUNC_LOAD, key, $urandom, $urandom);
        end
        repeat (nq) ask_query();
    endtask

    initial begin
        logic [31:0] base;
        int start;
        i_rst_n <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        s_axis_tuser <= FUNC_CLEAR;
        m_axis_tready <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_data <= 1'b0;
        cycles <= 0;
        items_sent = 0;
        set_idling(0);
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty table, duplicates, key extremes, misses, range edge cases
        write_mode(1'b0);
        send_item(FUNC_EXACT, 32'h0, 32'hFFFF_FFFF, 32'h0);
        send_item(FUNC_RANGE, 32'h0, 32'h0, 32'hFFFF_FFFF);
        send_item(FUNC_LOAD, 32'h0, 32'h0, 32'h0);
        send_item(FUNC_LOAD, 32'h5, 32'hFFFF_FFFF, 32'h0);
        send_item(FUNC_LOAD, 32'h5, 32'h1234_5678, 32'h0);
        send_item(FUNC_LOAD, 32'h5, 32'hA5A5_A5A5, 32'h0);
        send_item(FUNC_LOAD, 32'h0001_0005, 32'h5A5A_5A5A, 32'h0);
        send_item(FUNC_LOAD, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0);
        send_item(FUNC_EXACT, 32'h5, 32'h0, 32'h0);
        send_item(FUNC_EXACT, 32'h0, 32'h0, 32'h0);
        send_item(FUNC_EXACT, 32'hFFFF_FFFF, 32'h0, 32'h0);
        send_item(FUNC_EXACT, 32'h3, 32'h0, 32'h0);
        send_item(FUNC_RANGE, 32'h0, 32'h0, 32'hFFFF_FFFF);
        send_item(FUNC_RANGE, 32'h5, 32'h0, 32'h6);
        send_item(FUNC_RANGE, 32'h7, 32'h0, 32'h3);
        send_item(FUNC_RANGE, 32'h5, 32'h0, 32'h5);
        send_item(FUNC_RANGE, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF);
        // out-of-order load at the tail
        send_item(FUNC_LOAD, 32'h2, 32'hCAFE_0002, 32'h0);
        send_item(FUNC_EXACT, 32'h2, 32'h0, 32'h0);
        settle();
        write_mode(1'b1);
        send_item(FUNC_EXACT, 32'h7777_0005, 32'h0, 32'h0);
        send_item(FUNC_RANGE, 32'hFFFF_0000, 32'h0, 32'h0000_0006);
        // begin above end only once the bounds are cut to 16 bits
        send_item(FUNC_RANGE, 32'h0000_0009, 32'h0, 32'hFFFF_0003);
        settle();
        write_mode(1'b0);
        send_item(FUNC_CLEAR, 32'h0, 32'h0, 32'h0);
        send_item(FUNC_EXACT, 32'h5, 32'h0, 32'h0);

        // two runs of equal keys, together longer than the hit limit
        settle();
        set_idling(3);
        base = $urandom_range(0, 32'hFFFF_0000);
        send_item(FUNC_CLEAR, 32'h0, 32'h0, 32'h0);
        for (int i = 0; i < 2 * RUN_LEN; i++)
            send_item(FUNC_LOAD, base + 32'(i / RUN_LEN), $urandom, $urandom);
        send_item(FUNC_EXACT, base, 32'h0, 32'h0);
        send_item(FUNC_EXACT, base + 32'd1, 32'h0, 32'h0);
        send_item(FUNC_EXACT, base + 32'd2, 32'h0, 32'h0);
        send_item(FUNC_RANGE, base, 32'h0, base + 32'd2);
        send_item(FUNC_RANGE, base + 32'd1, 32'h0, base + 32'd2);
        send_item(FUNC_RANGE, 32'h0, 32'h0, 32'hFFFF_FFFF);

        // random phases: each idling pattern with both key modes
        for (int p = 0; p < 8; p++) begin
            settle();
            write_mode(p[0]);
            set_idling(p / 2);
            start = items_sent;
            while (items_sent - start < 4) begin
                if ($urandom_range(0, 99) < 8)
                    send_item(t_func'($urandom_range(0, 3)), $urandom, $urandom, $urandom);
                else
                    run_sequence();
            end
        end

        s_axis_tvalid <= 1'b0;
        while (sb.expected_hits.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
